/* sv/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and codes shared by the MIDI track event parser and its checker.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Event kinds on the result item
    localparam logic [3:0] K_NOTEOFF   = 4'd0;
    localparam logic [3:0] K_NOTEON    = 4'd1;
    localparam logic [3:0] K_SYSEX     = 4'd7;
    localparam logic [3:0] K_META      = 4'd8;
    localparam logic [3:0] K_END       = 4'd9;
    localparam logic [3:0] K_ERROR     = 4'd10;

    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [3:0] HI_PROGRAM        = 4'hC;
    localparam logic [3:0] HI_PRESSURE       = 4'hD;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_DELTA_MORE,
        PH_STATUS,
        PH_D1,
        PH_D2,
        PH_SYSLEN,
        PH_SKIP,
        PH_METATYPE,
        PH_METALEN
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_track;
        logic       last_of_track;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [3:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  payload_length;
        logic [31:0] event_time;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [27:0] delta_acc;
        logic [31:0] tick;
        logic [7:0]  held_first;
        logic [7:0]  held_meta;
        logic [7:0]  skip;
        logic        ended;
    } t_state;

endpackage

/* sv/mtep_step.sv */
// ----------------------------------------------------------------------------
// mtep_step
// Next-state and result logic for one track byte.
// ----------------------------------------------------------------------------
module mtep_step (
    input  mtep_pkg::t_state    i_state,
    input  mtep_pkg::t_in_item  i_item,
    output mtep_pkg::t_state    o_state,
    output logic                o_res_valid,
    output mtep_pkg::t_out_item o_res
);

    mtep_pkg::t_state s;
    mtep_pkg::t_state ns;
    logic [7:0]       b;
    logic [27:0]      acc_new;
    logic             take_data;
    logic             in_d1;
    logic [7:0]       cs;
    logic [3:0]       kind;
    logic [7:0]       d1;
    logic [7:0]       d2;

    always_comb begin
        s = i_state;
        if (i_item.start_of_track) begin
            s = '0;
            s.phase = mtep_pkg::PH_DELTA;
        end
        b         = i_item.data_byte;
        ns        = s;
        acc_new   = '0;
        take_data = 1'b0;
        in_d1     = 1'b0;
        cs        = s.current_status;
        kind      = mtep_pkg::K_NOTEOFF;
        d1        = '0;
        d2        = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!s.ended) begin
            case (s.phase)
                mtep_pkg::PH_DELTA, mtep_pkg::PH_DELTA_MORE: begin
                    if (s.phase == mtep_pkg::PH_DELTA) begin
                        acc_new = {21'd0, b[6:0]};
                    end else begin
                        acc_new = {s.delta_acc[20:0], b[6:0]};
                    end
                    if (b[7]) begin
                        ns.delta_acc = acc_new;
                        ns.phase     = mtep_pkg::PH_DELTA_MORE;
                    end else begin
                        ns.tick      = s.tick + {4'd0, acc_new};
                        ns.delta_acc = '0;
                        ns.phase     = mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    if (!b[7]) begin
                        if (s.running_status == 8'd0) begin
                            o_res_valid = 1'b1;
                            o_res.event_kind = mtep_pkg::K_ERROR;
                            ns.phase = mtep_pkg::PH_DELTA;
                        end else begin
                            // running status: this byte is the first data byte
                            ns.current_status = s.running_status;
                            cs        = s.running_status;
                            take_data = 1'b1;
                            in_d1     = 1'b1;
                        end
                    end else begin
                        ns.current_status = b;
                        if (b[7:4] != 4'hF) begin
                            ns.running_status = b;
                            ns.phase = mtep_pkg::PH_D1;
                        end else begin
                            ns.running_status = '0;
                            if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_SYSEX_ESC) begin
                                ns.phase = mtep_pkg::PH_SYSLEN;
                            end else if (b == mtep_pkg::STATUS_META) begin
                                ns.phase = mtep_pkg::PH_METATYPE;
                            end else begin
                                ns.phase = mtep_pkg::PH_DELTA;
                            end
                        end
                    end
                end
                mtep_pkg::PH_D1: begin
                    take_data = 1'b1;
                    in_d1     = 1'b1;
                end
                mtep_pkg::PH_D2: begin
                    take_data = 1'b1;
                end
                mtep_pkg::PH_SYSLEN: begin
                    o_res_valid = 1'b1;
                    o_res.event_kind     = mtep_pkg::K_SYSEX;
                    o_res.payload_length = b;
                    ns.skip  = b;
                    ns.phase = (b != 8'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                end
                mtep_pkg::PH_SKIP: begin
                    ns.skip = s.skip - 8'd1;
                    if (ns.skip == 8'd0) begin
                        ns.phase = mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_METATYPE: begin
                    ns.held_meta = b;
                    ns.phase     = mtep_pkg::PH_METALEN;
                end
                mtep_pkg::PH_METALEN: begin
                    o_res_valid = 1'b1;
                    o_res.first_data     = s.held_meta;
                    o_res.payload_length = b;
                    if (s.held_meta == mtep_pkg::META_END_OF_TRACK) begin
                        o_res.event_kind = mtep_pkg::K_END;
                        ns.ended = 1'b1;
                        ns.skip  = '0;
                        ns.phase = mtep_pkg::PH_DELTA;
                    end else begin
                        o_res.event_kind = mtep_pkg::K_META;
                        ns.skip  = b;
                        ns.phase = (b != 8'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                    end
                end
                default: begin
                    ns.phase = mtep_pkg::PH_DELTA;
                end
            endcase

            if (take_data) begin
                if (in_d1 && cs[7:4] != mtep_pkg::HI_PROGRAM && cs[7:4] != mtep_pkg::HI_PRESSURE) begin
                    // two-byte message: hold the first byte
                    ns.held_first = b;
                    ns.phase      = mtep_pkg::PH_D2;
                end else begin
                    d1 = in_d1 ? b : s.held_first;
                    d2 = in_d1 ? 8'd0 : b;
                    kind = {1'b0, cs[6:4]};
                    if (kind == mtep_pkg::K_NOTEON && d2 == 8'd0) begin
                        kind = mtep_pkg::K_NOTEOFF;
                    end
                    o_res_valid = 1'b1;
                    o_res.event_kind  = kind;
                    o_res.channel     = cs[3:0];
                    o_res.first_data  = d1;
                    o_res.second_data = d2;
                    ns.phase = mtep_pkg::PH_DELTA;
                end
            end

            if (i_item.last_of_track) begin
                // a track cut short inside an event or delta reports an error in place of any event
                if (!ns.ended && ns.phase != mtep_pkg::PH_DELTA) begin
                    o_res_valid = 1'b1;
                    o_res = '0;
                    o_res.event_kind = mtep_pkg::K_ERROR;
                end
                ns.phase     = mtep_pkg::PH_DELTA;
                ns.skip      = '0;
                ns.delta_acc = '0;
                ns.ended     = 1'b1;
            end
        end

        o_res.event_time = ns.tick;
        o_state = ns;
    end

endmodule

/* sv/midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses standard MIDI file track data, one byte per item, into events.
// ----------------------------------------------------------------------------
// Takes one track byte every cycle and gives at most one event per byte.
// A byte is held in the input register, is decoded there against the parser
// state, and its event (if any) is written to the output register, from which
// it is offered to the consumer. Throughput is one byte per cycle; it drops
// only while the output register holds an event that the consumer has not
// yet taken. Raise start_of_track on the first byte of each track; after
// end-of-track or last_of_track bytes are ignored until then.
module midi_track_event_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mtep_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mtep_pkg::t_out_item o_out_item
);

    logic                r_in_vld;
    mtep_pkg::t_in_item  r_in;
    mtep_pkg::t_state    r_state;
    mtep_pkg::t_state    n_state;
    logic                r_out_vld;
    mtep_pkg::t_out_item r_out;
    logic                res_vld;
    mtep_pkg::t_out_item res;
    logic                adv;

    // advance the held byte once the result register can take its event
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    mtep_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (res_vld),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            // all-zero state is the delta-time phase with everything cleared
            r_state   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_state   <= n_state;
                r_out_vld <= res_vld;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
        if (adv && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

/* sv/mtep_checker.sv */
// ----------------------------------------------------------------------------
// mtep_checker
// Port-level checks on the MIDI track event parser's result channel.
// ----------------------------------------------------------------------------
module mtep_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input mtep_pkg::t_out_item i_out_item
);

    // hold an unaccepted event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_item.event_kind <= mtep_pkg::K_ERROR)
        else $error("event kind out of range");

    a_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.event_kind >= mtep_pkg::K_SYSEX
        |-> i_out_item.channel == 4'd0 && i_out_item.second_data == 8'd0)
        else $error("non-channel event carries channel data");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.event_kind < mtep_pkg::K_SYSEX
                        || i_out_item.event_kind == mtep_pkg::K_ERROR)
        |-> i_out_item.payload_length == 8'd0)
        else $error("payload length on an event without one");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

/* verif/mtep_tb_pkg.sv */
// ----------------------------------------------------------------------------
// mtep_tb_pkg
// Event predictor and scoreboard for the MIDI track event parser bench.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own copy of the parser state. Each accepted byte is
// decoded into the event it should cause, if any. Each event from the block is
// checked field by field against the oldest event still awaited.
package mtep_tb_pkg;

    import mtep_pkg::*;

    class event_scoreboard;

        t_phase      phase;
        logic [7:0]  run_status;
        logic [7:0]  cur_status;
        logic [7:0]  first_held;
        logic [7:0]  held_type;
        logic [7:0]  skip_left;
        logic [27:0] delta_acc;
        logic [31:0] ticks;
        bit          ended;
        t_out_item   expected_events[$];
        int unsigned failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            phase      = PH_DELTA;
            run_status = 8'h00;
            cur_status = 8'h00;
            first_held = 8'h00;
            held_type  = 8'h00;
            skip_left  = 8'h00;
            delta_acc  = 28'h0;
            ticks      = 32'h0;
            ended      = 1'b0;
        endfunction

        function t_out_item make_event(logic [3:0] kind, logic [3:0] chan, logic [7:0] d1,
                                       logic [7:0] d2, logic [7:0] len);
            t_out_item ev;
            ev.event_kind     = kind;
            ev.channel        = chan;
            ev.first_data     = d1;
            ev.second_data    = d2;
            ev.payload_length = len;
            ev.event_time     = ticks;
            return ev;
        endfunction

        function t_out_item channel_event(logic [7:0] d1, logic [7:0] d2);
            logic [3:0] kind;
            kind = cur_status[7:4] - 4'd8;
            // note-on with zero velocity is a note-off
            if (kind == K_NOTEON && d2 == 8'h00) kind = K_NOTEOFF;
            return make_event(kind, cur_status[3:0], d1, d2, 8'h00);
        endfunction

        function bit take_data(input logic [7:0] b, output t_out_item ev);
            ev = '0;
            if (phase == PH_D1 && cur_status[7:4] != HI_PROGRAM &&
                cur_status[7:4] != HI_PRESSURE) begin
                first_held = b;
                phase      = PH_D2;
                return 1'b0;
            end
            ev    = (phase == PH_D1) ? channel_event(b, 8'h00) : channel_event(first_held, b);
            phase = PH_DELTA;
            return 1'b1;
        endfunction

        // Returns 1 when the byte was taken by the parser, 0 when ignored.
        function bit note_byte(t_in_item it);
            bit         have;
            t_out_item  ev;
            logic [7:0] b;
            b    = it.data_byte;
            have = 1'b0;
            ev   = '0;
            if (it.start_of_track) clear();
            if (ended) return 1'b0;
            case (phase)
                PH_DELTA, PH_DELTA_MORE: begin
                    if (phase == PH_DELTA) delta_acc = {21'h0, b[6:0]};
                    else delta_acc = {delta_acc[20:0], b[6:0]};
                    if (b[7]) begin
                        phase = PH_DELTA_MORE;
                    end else begin
                        ticks     = ticks + {4'h0, delta_acc};
                        delta_acc = 28'h0;
                        phase     = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!b[7]) begin
                        if (run_status == 8'h00) begin
                            ev    = make_event(K_ERROR, 4'h0, 8'h00, 8'h00, 8'h00);
                            have  = 1'b1;
                            phase = PH_DELTA;
                        end else begin
                            cur_status = run_status;
                            phase      = PH_D1;
                            have       = take_data(b, ev);
                        end
                    end else begin
                        cur_status = b;
                        if (b < 8'hF0) begin
                            run_status = b;
                            phase      = PH_D1;
                        end else begin
                            run_status = 8'h00;
                            if (b == STATUS_SYSEX || b == STATUS_SYSEX_ESC) phase = PH_SYSLEN;
                            else if (b == STATUS_META) phase = PH_METATYPE;
                            else phase = PH_DELTA;
                        end
                    end
                end
                PH_D1, PH_D2: begin
                    have = take_data(b, ev);
                end
                PH_SYSLEN: begin
                    ev        = make_event(K_SYSEX, 4'h0, 8'h00, 8'h00, b);
                    have      = 1'b1;
                    skip_left = b;
                    phase     = (b != 8'h00) ? PH_SKIP : PH_DELTA;
                end
                PH_SKIP: begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'h00) phase = PH_DELTA;
                end
                PH_METATYPE: begin
                    held_type = b;
                    phase     = PH_METALEN;
                end
                PH_METALEN: begin
                    have = 1'b1;
                    if (held_type == META_END_OF_TRACK) begin
                        ev        = make_event(K_END, 4'h0, META_END_OF_TRACK, 8'h00, b);
                        ended     = 1'b1;
                        skip_left = 8'h00;
                        phase     = PH_DELTA;
                    end else begin
                        ev        = make_event(K_META, 4'h0, held_type, 8'h00, b);
                        skip_left = b;
                        phase     = (b != 8'h00) ? PH_SKIP : PH_DELTA;
                    end
                end
                default: begin
                    phase = PH_DELTA;
                end
            endcase
            // a track cut off inside an event or delta replaces any event with an error
            if (it.last_of_track) begin
                if (!ended && phase != PH_DELTA) begin
                    ev   = make_event(K_ERROR, 4'h0, 8'h00, 8'h00, 8'h00);
                    have = 1'b1;
                end
                phase     = PH_DELTA;
                skip_left = 8'h00;
                delta_acc = 28'h0;
                ended     = 1'b1;
            end
            if (have) expected_events = {expected_events, ev};
            return 1'b1;
        endfunction

        function void check_event(t_out_item got);
            t_out_item exp;
            if (expected_events.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected event: kind %0d ch %0d d1 %02h d2 %02h len %0d t %0d",
                             got.event_kind, got.channel, got.first_data, got.second_data,
                             got.payload_length, got.event_time);
                return;
            end
            exp = expected_events.pop_front();
            if (got.event_kind !== exp.event_kind || got.channel !== exp.channel ||
                got.first_data !== exp.first_data || got.second_data !== exp.second_data ||
                got.payload_length !== exp.payload_length ||
                got.event_time !== exp.event_time) begin
                failures++;
                if (failures <= 10) begin
                    $display("event mismatch: expected kind %0d ch %0d d1 %02h d2 %02h len %0d t %0d",
                             exp.event_kind, exp.channel, exp.first_data, exp.second_data,
                             exp.payload_length, exp.event_time);
                    $display("                got      kind %0d ch %0d d1 %02h d2 %02h len %0d t %0d",
                             got.event_kind, got.channel, got.first_data, got.second_data,
                             got.payload_length, got.event_time);
                end
            end
        endfunction

    endclass

endpackage

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIDI track event parser.
// ----------------------------------------------------------------------------
// Feeds a short hand-written pair of tracks, then random tracks
// with random content, truncated tracks and loose noise bytes. Both sides of
// the block stall at random, apart from one calm stretch. Every event is
// checked against the scoreboard's own decode of the accepted bytes.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mtep_pkg::*;
    import mtep_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 1300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    event_scoreboard sb;
    logic [7:0]      track_bytes[$];
    int              bytes_taken;
    int              stall_cycles = 0;
    bit              calm;

    midi_track_event_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Check events and drive the consumer's ready
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1) sb.check_event(o_out_item);
        i_out_ready <= calm || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("midi_track_event_parser test failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_data();
        // mostly proper 7-bit data, now and then a byte with the high bit set
        return ($urandom_range(19) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(127));
    endfunction

    function automatic int rand_payload_len();
        return ($urandom_range(49) == 0) ? $urandom_range(100, 255) : $urandom_range(4);
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        track_bytes = {track_bytes, v};
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit sot, input bit lot);
        t_in_item it;
        it.data_byte      = b;
        it.start_of_track = sot;
        it.last_of_track  = lot;
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        void'(sb.note_byte(it));
        bytes_taken++;
    endtask

    task automatic send_track();
        for (int i = 0; i < track_bytes.size(); i++)
            send_byte(track_bytes[i], i == 0, i == track_bytes.size() - 1);
    endtask

    task automatic build_track();
        int         n_events;
        int         pick;
        int         len;
        bit         big;
        bit         have_rs;
        logic [3:0] hi;
        logic [7:0] b;
        track_bytes.delete();
        big      = ($urandom_range(3) == 0);
        // long-delta tracks run long enough to wrap the tick count
        n_events = big ? $urandom_range(18, 30) : $urandom_range(3, 30);
        have_rs  = 1'b0;
        hi       = 4'h9;
        repeat (n_events) begin
            pick = $urandom_range(9);
            if (big) begin
                if ($urandom_range(3) == 0) add_byte(8'($urandom_range(128, 255)));
                add_byte(8'hFF);
                add_byte(8'hFF);
                add_byte(8'hFF);
                add_byte(8'($urandom_range(127)));
            end else if (pick < 6) begin
                add_byte(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(127)));
            end else begin
                repeat ((pick < 9) ? 1 : $urandom_range(2, 4))
                    add_byte(8'($urandom_range(128, 255)));
                add_byte(8'($urandom_range(127)));
            end

            pick = $urandom_range(99);
            if (pick < 55) begin
                if (!have_rs || $urandom_range(2) == 0) begin
                    hi = 4'($urandom_range(8, 14));
                    add_byte({hi, 4'($urandom_range(15))});
                    have_rs = 1'b1;
                end
                add_byte(rand_data());
                if (hi != HI_PROGRAM && hi != HI_PRESSURE)
                    add_byte((hi == 4'h9 && $urandom_range(5) == 0) ? 8'h00 : rand_data());
            end else if (pick < 80) begin
                if (pick < 65) begin
                    add_byte($urandom_range(1) ? STATUS_SYSEX : STATUS_SYSEX_ESC);
                end else begin
                    b = 8'($urandom_range(255));
                    add_byte(STATUS_META);
                    add_byte((b == META_END_OF_TRACK) ? 8'h01 : b);
                end
                len = rand_payload_len();
                add_byte(8'(len));
                repeat (len) add_byte(8'($urandom_range(255)));
                have_rs = 1'b0;
            end else if (pick < 85) begin
                b = 8'($urandom_range(8'hF1, 8'hFE));
                add_byte((b == STATUS_SYSEX_ESC) ? 8'hF6 : b);
                have_rs = 1'b0;
            end else if (pick < 92) begin
                add_byte(8'($urandom_range(127)));
            end else begin
                add_byte(8'($urandom_range(255)));
            end
        end

        pick = $urandom_range(99);
        if (pick < 65) begin
            add_byte(8'h00);
            add_byte(STATUS_META);
            add_byte(META_END_OF_TRACK);
            add_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00);
            // trailing bytes after the end event are dropped by the parser
            repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3))
                if (track_bytes.size() > 1) void'(track_bytes.pop_back());
        end
    endtask

    initial begin
        sb           = new();
        bytes_taken  = 0;
        calm         = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data with no running status, overlong delta, note-on at zero velocity,
        // running status with a high-bit data byte, program, system status,
        // sysex with skip, end of track, then a byte ignored after the end
        track_bytes = '{8'h00, 8'h7F,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9F, 8'h7F, 8'h00,
                        8'h81, 8'h00, 8'h3C, 8'hFF,
                        8'h00, 8'hC2, 8'h80,
                        8'h00, 8'hF5,
                        8'h00, 8'hF0, 8'h01, 8'hAA,
                        8'h00, 8'hFF, 8'h2F, 8'h00,
                        8'h55};
        send_track();
        // pitch bend, empty meta, then the track cut off inside a control change
        track_bytes = '{8'h00, 8'hE4, 8'h00, 8'h40,
                        8'h00, 8'hFF, 8'h01, 8'h00,
                        8'h00, 8'hB1, 8'h07};
        send_track();

        while (bytes_taken < BYTE_TARGET) begin
            calm = (bytes_taken >= 400 && bytes_taken < 650);
            if ($urandom_range(19) == 0) begin
                repeat ($urandom_range(5, 20))
                    send_byte(8'($urandom_range(255)), $urandom_range(9) == 0,
                              $urandom_range(9) == 0);
            end else begin
                build_track();
                send_track();
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_events.size() == 0) begin
            $display("midi_track_event_parser test passed");
        end else begin
            $display("midi_track_event_parser test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/mtep_pkg.sv
sv/mtep_step.sv
sv/midi_track_event_parser.sv
sv/mtep_checker.sv
verif/mtep_tb_pkg.sv
verif/testbench.sv
